FILE: rtl/cnmf_pkg.sv
package cnmf_pkg;

    localparam int PIX_W   = 16;
    localparam int SUM_W   = 19;   // five 16-bit terms
    localparam int MAG_W   = 18;   // |sum| <= 5 * 32768
    localparam int CNT_W   = 3;
    localparam int MEAN_W  = 24;
    localparam int FRAC_W  = 8;
    localparam int RCP_W   = 25;
    localparam int RCP_SHIFT = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_SELF = 2'd2;

    // ceil(2^24 / cnt); exact floor division for magnitudes below 2^18
    function automatic logic [RCP_W-1:0] recip_lut(input logic [CNT_W-1:0] cnt);
        logic [RCP_W-1:0] m;
        case (cnt)
            3'd1:    m = 25'd16777216;
            3'd2:    m = 25'd8388608;
            3'd3:    m = 25'd5592406;
            3'd4:    m = 25'd4194304;
            3'd5:    m = 25'd3355444;
            default: m = '0;
        endcase
        return m;
    endfunction

    // floor((rem * 256 + cnt / 2) / cnt)
    function automatic logic [FRAC_W-1:0] frac_lut(input logic [CNT_W-1:0] cnt,
                                                   input logic [CNT_W-1:0] rem);
        logic [FRAC_W-1:0] f;
        case ({cnt, rem})
            {3'd2, 3'd1}: f = 8'd128;
            {3'd3, 3'd1}: f = 8'd85;
            {3'd3, 3'd2}: f = 8'd171;
            {3'd4, 3'd1}: f = 8'd64;
            {3'd4, 3'd2}: f = 8'd128;
            {3'd4, 3'd3}: f = 8'd192;
            {3'd5, 3'd1}: f = 8'd51;
            {3'd5, 3'd2}: f = 8'd102;
            {3'd5, 3'd3}: f = 8'd154;
            {3'd5, 3'd4}: f = 8'd205;
            default:      f = '0;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/cnmf_mean.sv
module cnmf_mean
    import cnmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [SUM_W-1:0]  i_sum,
    input  logic [CNT_W-1:0]         i_cnt,
    output logic [MEAN_W-1:0]        o_mean,
    output logic                     o_no_neighbours
);

    logic [SUM_W-1:0]         w_abs;
    logic [MAG_W-1:0]         w_mag;
    logic [MAG_W+RCP_W-1:0]   w_prod;

    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic [MAG_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;

    logic [MAG_W-1:0]         w_back;
    logic [MAG_W-1:0]         w_diff;
    logic [FRAC_W-1:0]        w_frac;
    logic [MAG_W+FRAC_W-1:0]  w_q;
    logic [MAG_W+FRAC_W-1:0]  w_q_neg;

    assign w_abs  = i_sum[SUM_W-1] ? (-i_sum) : i_sum;
    assign w_mag  = w_abs[MAG_W-1:0];
    assign w_prod = w_mag * recip_lut(i_cnt);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_sum[SUM_W-1];
            r_mag <= w_mag;
            r_cnt <= i_cnt;
            r_quo <= w_prod[RCP_SHIFT+MAG_W-1:RCP_SHIFT];
        end
    end

    // remainder is below cnt, so it fits the low bits
    assign w_back  = r_quo * MAG_W'(r_cnt);
    assign w_diff  = r_mag - w_back;
    assign w_frac  = frac_lut(r_cnt, w_diff[CNT_W-1:0]);
    assign w_q     = {r_quo, w_frac};
    assign w_q_neg = ~w_q + 1'b1;

    assign o_no_neighbours = (r_cnt == '0);
    assign o_mean = (r_cnt == '0) ? '0 :
                    r_neg ? w_q_neg[MEAN_W-1:0] : w_q[MEAN_W-1:0];

endmodule

FILE: rtl/cross_neighbour_mean_filter_top.sv
// A result is presented once the item that completes it has passed S_READ, S_MUL and S_FIN.
// An item is taken only in S_IDLE; one that yields a result passes S_READ, S_MUL and S_FIN
// (held while the output stalls), a first-row one S_READ only, and a pad during the frame is
// dropped at once; set by the line-store read-modify-write and two-step reciprocal divide.
// Reset (i_rst_n low, synchronous) clears counters, state and output valid; registers
// return to width 3, height 3, self on. Line stores are not cleared.
module cross_neighbour_mean_filter_top
    import cnmf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [PIX_W-1:0]        i_s_axis_tdata,   // [15:0] pixel
    input  logic                    i_s_axis_tuser,   // [0] is_pad
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [MEAN_W-1:0]       o_m_axis_tdata,   // [23:0] mean_value
    output logic                    o_m_axis_tuser,   // [0] no_neighbours
    output logic                    o_m_axis_tlast,   // frame_last
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [10:0]             r_cfg_width;
    logic [15:0]             r_cfg_height;
    logic                    r_cfg_self;

    logic [CW-1:0]           r_col;
    logic [15:0]             r_row;
    logic signed [PIX_W-1:0] r_prev;
    logic signed [PIX_W-1:0] r_px;

    logic signed [PIX_W-1:0] r_above_mem  [MAX_WIDTH];
    logic signed [PIX_W-1:0] r_centre_mem [MAX_WIDTH];
    logic signed [PIX_W-1:0] r_above_rd;
    logic signed [PIX_W-1:0] r_centre_rd;
    logic signed [PIX_W-1:0] r_right_rd;

    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_last;

    logic                    r_out_valid;
    logic [MEAN_W-1:0]       r_out_mean;
    logic                    r_out_nonb;
    logic                    r_out_last;

    logic [WW-1:0]           w_w;
    logic [15:0]             w_h;
    logic [WW-1:0]           w_col_ext;
    logic [WW-1:0]           w_c_full;
    logic [CW-1:0]           w_c;
    logic [CW-1:0]           w_c_next;
    logic                    w_last;
    logic                    w_flush;
    logic                    w_first_row;
    logic                    w_s_accept;
    logic                    w_out_free;
    logic                    w_use_above;
    logic                    w_use_left;
    logic                    w_use_right;
    logic                    w_use_px;
    logic signed [SUM_W-1:0] w_sum;
    logic [CNT_W-1:0]        w_cnt;
    logic [MEAN_W-1:0]       w_mean;
    logic                    w_nonb;

    // effective limits
    assign w_w = (r_cfg_width == '0) ? WW'(1) :
                 (32'(r_cfg_width) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_cfg_width);
    assign w_h = (r_cfg_height == '0) ? 16'd1 : r_cfg_height;

    assign w_col_ext   = WW'(r_col);
    assign w_c_full    = (w_col_ext < w_w) ? w_col_ext : (w_w - WW'(1));
    assign w_c         = w_c_full[CW-1:0];
    assign w_last      = (w_c_full == (w_w - WW'(1)));
    assign w_c_next    = (32'(w_c) == MAX_WIDTH - 1) ? '0 : (w_c + CW'(1));
    assign w_flush     = (r_row >= w_h);
    assign w_first_row = !w_flush && (r_row == '0);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_use_above = w_flush ? (w_h >= 16'd2) : (r_row >= 16'd2);
    assign w_use_left  = (w_c != '0);
    assign w_use_right = !w_last;
    assign w_use_px    = !w_flush;

    assign w_sum = (w_use_above ? SUM_W'(r_above_rd)  : SUM_W'(0))
                 + (w_use_left  ? SUM_W'(r_prev)      : SUM_W'(0))
                 + (w_use_right ? SUM_W'(r_right_rd)  : SUM_W'(0))
                 + (w_use_px    ? SUM_W'(r_px)        : SUM_W'(0))
                 + (r_cfg_self  ? SUM_W'(r_centre_rd) : SUM_W'(0));
    assign w_cnt = CNT_W'(w_use_above) + CNT_W'(w_use_left) + CNT_W'(w_use_right)
                 + CNT_W'(w_use_px) + CNT_W'(r_cfg_self);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd3;
            r_cfg_height <= 16'd3;
            r_cfg_self   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[10:0];
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_INCLUDE_SELF: r_cfg_self   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // line stores: reads issued on accept, written back in S_READ outside the flush rows
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_above_rd  <= r_above_mem[w_c];
            r_centre_rd <= r_centre_mem[w_c];
            r_right_rd  <= r_centre_mem[w_c_next];
        end
        if ((r_state == S_READ) && !w_flush) begin
            r_above_mem[w_c]  <= r_centre_rd;
            r_centre_mem[w_c] <= r_px;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_accept && !(i_s_axis_tuser && !w_flush)) n_state = S_READ;
            end
            S_READ: n_state = w_first_row ? S_IDLE : S_MUL;
            S_MUL:  n_state = S_FIN;
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_prev  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_prev <= r_centre_rd;
                if (w_last) begin
                    r_col <= '0;
                    r_row <= w_flush ? 16'd0 : (r_row + 16'd1);
                end else begin
                    r_col <= w_c + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) r_px <= i_s_axis_tdata;
        if (r_state == S_READ) begin
            r_sum  <= w_sum;
            r_cnt  <= w_cnt;
            r_last <= w_flush && w_last;
        end
    end

    cnmf_mean u_mean (
        .i_clk           (i_clk),
        .i_load          (r_state == S_MUL),
        .i_sum           (r_sum),
        .i_cnt           (r_cnt),
        .o_mean          (w_mean),
        .o_no_neighbours (w_nonb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_mean <= w_mean;
            r_out_nonb <= w_nonb;
            r_out_last <= r_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_mean;
    assign o_m_axis_tuser  = r_out_nonb;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) && w_flush && w_last |=> (r_row == '0) && (r_col == '0))
        else $error("counters not cleared at frame end");

    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_accept && !(i_s_axis_tuser && !w_flush) |=> (r_state == S_READ))
        else $error("accepted item not processed");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result appeared outside final step");

    a_zero_on_nonb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_nonb |-> (r_out_mean == '0))
        else $error("mean not zero with no neighbours");
`endif

endmodule
